// File: rtl/segment_obstacle_visibility_assert.svh
// Assertion macros for the segment obstacle visibility checker.
// Expects signals named clk and rst_n in the scope that uses them.
`ifndef SEGMENT_OBSTACLE_VISIBILITY_ASSERT_SVH
`define SEGMENT_OBSTACLE_VISIBILITY_ASSERT_SVH

// Checked only while out of reset.
`define SOV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SOV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/sov_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the segment obstacle visibility block.
// No dependencies.
package sov_pkg;

  localparam int MAX_OBSTACLES_DEF = 64;
  localparam int CMDQ_DEPTH        = 2;
  localparam int COORD_W           = 16;
  localparam int COUNT_OUT_W       = 7;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_ADD,
    CMD_QUERY,
    CMD_IGNORE
  } cmd_kind_t;

  // Add carries left, right, top, bottom; query carries start x/y, end x/y.
  typedef struct packed {
    cmd_kind_t                  kind;
    logic signed [COORD_W-1:0]  c0;
    logic signed [COORD_W-1:0]  c1;
    logic signed [COORD_W-1:0]  c2;
    logic signed [COORD_W-1:0]  c3;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_t;

endpackage

// File: rtl/sov_front.sv
`timescale 1ns / 1ps
// Front end: accepts input transfers, decodes the mode and packs a command.
// Depends on sov_pkg.
module sov_front import sov_pkg::*; (
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                in_mode,
  input  logic signed [COORD_W-1:0] in_obs_left,
  input  logic signed [COORD_W-1:0] in_obs_right,
  input  logic signed [COORD_W-1:0] in_obs_top,
  input  logic signed [COORD_W-1:0] in_obs_bottom,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_y,
  input  logic signed [COORD_W-1:0] in_end_x,
  input  logic signed [COORD_W-1:0] in_end_y,
  output logic                      q_push,
  output cmd_t                      q_cmd,
  input  logic                      q_full
);

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_cmd = '0;
    unique case (in_mode)
      MODE_CLEAR: begin
        q_cmd.kind = CMD_CLEAR;
      end
      MODE_ADD: begin
        q_cmd.kind = CMD_ADD;
        q_cmd.c0   = in_obs_left;
        q_cmd.c1   = in_obs_right;
        q_cmd.c2   = in_obs_top;
        q_cmd.c3   = in_obs_bottom;
      end
      MODE_QUERY: begin
        q_cmd.kind = CMD_QUERY;
        q_cmd.c0   = in_start_x;
        q_cmd.c1   = in_start_y;
        q_cmd.c2   = in_end_x;
        q_cmd.c3   = in_end_y;
      end
      default: begin
        q_cmd.kind = CMD_IGNORE;
      end
    endcase
  end

endmodule

// File: rtl/sov_cmdq.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on sov_pkg.
module sov_cmdq import sov_pkg::*; #(
  parameter int DEPTH = CMDQ_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_push,
  input  cmd_t q_wdata,
  output logic q_full,
  input  logic q_pop,
  output cmd_t q_rdata,
  output logic q_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  cmd_t            slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign q_full  = (cnt_r == NW'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_rdata = slot_r[rd_ptr_r];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

// File: rtl/sov_back.sv
`timescale 1ns / 1ps
// Back end: owns the obstacle table and count, runs clear/add at once and
// scans the table one entry per cycle for a query. Depends on sov_pkg.
module sov_back import sov_pkg::*; #(
  parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF,
  parameter int CW            = $clog2(MAX_OBSTACLES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  cmd_t          q_cmd,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic          out_visible,
  output logic          out_status,
  output logic [CW-1:0] out_count
);

  localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int EW = 4 * COORD_W;

  back_state_t state_r, state_nxt;

  logic [EW-1:0] table_mem [MAX_OBSTACLES];
  logic [EW-1:0] rdata_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_visible_r, out_visible_nxt;
  logic          out_status_r, out_status_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;
  logic          blocked_r, blocked_nxt;
  logic          v1_r, v2_r, v3_r;

  logic          slot_free, mem_we, rd_en, load_seg, clr_blocked;

  // Query segment, held for the whole scan.
  logic signed [COORD_W-1:0] sx_r, sy_r, ex_r, ey_r;
  logic signed [COORD_W:0]   dx_r, dy_r;

  // Stage 2: corner offsets from the segment start, and the edge pass test.
  logic signed [COORD_W-1:0] e_l, e_r, e_t, e_b;
  logic signed [COORD_W:0]   qxr_r, qxl_r, qyt_r, qyb_r;
  logic                      pass2_r, pass_nxt;

  // Stage 3: partial cross products.
  logic signed [2*COORD_W+1:0] pxr_r, pxl_r, pyt_r, pyb_r;
  logic                        pass3_r;

  // Stage 4: corner signs.
  logic [2*COORD_W+2:0] cv [4];
  logic                 any_neg, any_pos, blk;

  assign slot_free   = !out_valid_r || pop;
  assign empty       = !out_valid_r;
  assign out_visible = out_visible_r;
  assign out_status  = out_status_r;
  assign out_count   = out_count_r;

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    issue_nxt       = issue_r;
    out_valid_nxt   = out_valid_r && !pop;
    out_visible_nxt = out_visible_r;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    q_pop           = 1'b0;
    mem_we          = 1'b0;
    rd_en           = 1'b0;
    load_seg        = 1'b0;
    clr_blocked     = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty && slot_free) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            CMD_CLEAR: begin
              count_nxt       = '0;
              out_valid_nxt   = 1'b1;
              out_visible_nxt = 1'b0;
              out_status_nxt  = 1'b0;
              out_count_nxt   = '0;
            end
            CMD_ADD: begin
              out_valid_nxt   = 1'b1;
              out_visible_nxt = 1'b0;
              if (count_r == CW'(MAX_OBSTACLES)) begin
                out_status_nxt = 1'b1;
                out_count_nxt  = count_r;
              end else begin
                mem_we         = 1'b1;
                count_nxt      = count_r + 1'b1;
                out_status_nxt = 1'b0;
                out_count_nxt  = count_r + 1'b1;
              end
            end
            CMD_QUERY: begin
              load_seg    = 1'b1;
              clr_blocked = 1'b1;
              issue_nxt   = '0;
              state_nxt   = BK_SCAN;
            end
            default: begin
              out_valid_nxt   = 1'b1;
              out_visible_nxt = 1'b0;
              out_status_nxt  = 1'b0;
              out_count_nxt   = count_r;
            end
          endcase
        end
      end
      BK_SCAN: begin
        rd_en = (issue_r < count_r);
        if (rd_en) begin
          issue_nxt = issue_r + 1'b1;
        end else if (!v1_r && !v2_r && !v3_r) begin
          // The output slot was free at dispatch and nothing else fills it.
          out_valid_nxt   = 1'b1;
          out_visible_nxt = !blocked_r;
          out_status_nxt  = 1'b0;
          out_count_nxt   = count_r;
          state_nxt       = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Stage 2 logic: a segment wholly beyond one edge never blocks.
  assign e_l = rdata_r[COORD_W-1:0];
  assign e_r = rdata_r[2*COORD_W-1:COORD_W];
  assign e_t = rdata_r[3*COORD_W-1:2*COORD_W];
  assign e_b = rdata_r[4*COORD_W-1:3*COORD_W];

  assign pass_nxt = (sx_r >= e_r && ex_r >= e_r) || (sx_r <= e_l && ex_r <= e_l) ||
                    (sy_r <= e_t && ey_r <= e_t) || (sy_r >= e_b && ey_r >= e_b);

  // Stage 4 logic: cross product dy*(px-sx) - dx*(py-sy) for each corner.
  always_comb begin
    cv[0] = {pxr_r[2*COORD_W+1], pxr_r} - {pyt_r[2*COORD_W+1], pyt_r};
    cv[1] = {pxl_r[2*COORD_W+1], pxl_r} - {pyt_r[2*COORD_W+1], pyt_r};
    cv[2] = {pxl_r[2*COORD_W+1], pxl_r} - {pyb_r[2*COORD_W+1], pyb_r};
    cv[3] = {pxr_r[2*COORD_W+1], pxr_r} - {pyb_r[2*COORD_W+1], pyb_r};
    any_neg = 1'b0;
    any_pos = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (cv[i][2*COORD_W+2]) begin
        any_neg = 1'b1;
      end else if (cv[i] != '0) begin
        any_pos = 1'b1;
      end
    end
    blk = any_neg && any_pos && !pass3_r;
  end

  always_comb begin
    if (clr_blocked) begin
      blocked_nxt = 1'b0;
    end else begin
      blocked_nxt = blocked_r || (v3_r && blk);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      issue_r     <= '0;
      out_valid_r <= 1'b0;
      blocked_r   <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      out_valid_r <= out_valid_nxt;
      blocked_r   <= blocked_nxt;
      v1_r        <= rd_en;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    out_visible_r <= out_visible_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
    if (load_seg) begin
      sx_r <= q_cmd.c0;
      sy_r <= q_cmd.c1;
      ex_r <= q_cmd.c2;
      ey_r <= q_cmd.c3;
      dx_r <= (COORD_W+1)'($signed(q_cmd.c2)) - (COORD_W+1)'($signed(q_cmd.c0));
      dy_r <= (COORD_W+1)'($signed(q_cmd.c3)) - (COORD_W+1)'($signed(q_cmd.c1));
    end
  end

  // Obstacle table: one write port for add, one registered read port for scan.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[count_r[AW-1:0]] <= {q_cmd.c3, q_cmd.c2, q_cmd.c1, q_cmd.c0};
    end
    if (rd_en) begin
      rdata_r <= table_mem[issue_r[AW-1:0]];
    end
  end

  // The products take sign-extended 17-bit operands.
  always_ff @(posedge clk) begin
    qxr_r   <= (COORD_W+1)'(e_r) - (COORD_W+1)'(sx_r);
    qxl_r   <= (COORD_W+1)'(e_l) - (COORD_W+1)'(sx_r);
    qyt_r   <= (COORD_W+1)'(e_t) - (COORD_W+1)'(sy_r);
    qyb_r   <= (COORD_W+1)'(e_b) - (COORD_W+1)'(sy_r);
    pass2_r <= pass_nxt;
    pxr_r   <= (2*COORD_W+2)'(dy_r) * (2*COORD_W+2)'(qxr_r);
    pxl_r   <= (2*COORD_W+2)'(dy_r) * (2*COORD_W+2)'(qxl_r);
    pyt_r   <= (2*COORD_W+2)'(dx_r) * (2*COORD_W+2)'(qyt_r);
    pyb_r   <= (2*COORD_W+2)'(dx_r) * (2*COORD_W+2)'(qyb_r);
    pass3_r <= pass2_r;
  end

endmodule

// File: rtl/segment_obstacle_visibility.sv
`timescale 1ns / 1ps
// Top level of the segment obstacle visibility block: front end, command
// queue and back end. Depends on sov_pkg, sov_front, sov_cmdq, sov_back.
//
//   Channel  Handshake      Payload
//   input    push / full    in_mode, in_obs_*, in_start_*, in_end_*
//   result   empty / pop    out_visible, out_status, out_stored_count
//
// Clear, add and an unused mode are each handled straight from the idle state.
// A query scans the stored entries: the table has one read port, read one
// obstacle per cycle, followed by a three-stage cross product pipe.
// Reset is synchronous; it empties both queues and zeroes the count. Table
// contents are not cleared, since only entries below the count are read.
// The command queue keeps accepting transfers, until it is full, while the back
// end scans or while a result waits; only the back end stalls on a waiting result.
module segment_obstacle_visibility import sov_pkg::*; #(
  parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    in_mode,
  input  logic signed [COORD_W-1:0]     in_obs_left,
  input  logic signed [COORD_W-1:0]     in_obs_right,
  input  logic signed [COORD_W-1:0]     in_obs_top,
  input  logic signed [COORD_W-1:0]     in_obs_bottom,
  input  logic signed [COORD_W-1:0]     in_start_x,
  input  logic signed [COORD_W-1:0]     in_start_y,
  input  logic signed [COORD_W-1:0]     in_end_x,
  input  logic signed [COORD_W-1:0]     in_end_y,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_visible,
  output logic                          out_status,
  output logic [COUNT_OUT_W-1:0]        out_stored_count
);

  localparam int CW = $clog2(MAX_OBSTACLES + 1);

  logic          fq_push, fq_full, bq_pop, bq_empty;
  cmd_t          fq_cmd, bq_cmd;
  logic [CW-1:0] back_count;

  sov_front u_front (
    .push          (push),
    .full          (full),
    .in_mode       (in_mode),
    .in_obs_left   (in_obs_left),
    .in_obs_right  (in_obs_right),
    .in_obs_top    (in_obs_top),
    .in_obs_bottom (in_obs_bottom),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .q_push        (fq_push),
    .q_cmd         (fq_cmd),
    .q_full        (fq_full)
  );

  sov_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (fq_push),
    .q_wdata (fq_cmd),
    .q_full  (fq_full),
    .q_pop   (bq_pop),
    .q_rdata (bq_cmd),
    .q_empty (bq_empty)
  );

  sov_back #(
    .MAX_OBSTACLES (MAX_OBSTACLES),
    .CW            (CW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (bq_empty),
    .q_cmd       (bq_cmd),
    .q_pop       (bq_pop),
    .empty       (empty),
    .pop         (pop),
    .out_visible (out_visible),
    .out_status  (out_status),
    .out_count   (back_count)
  );

  // The reported count is the low bits of the table count.
  assign out_stored_count = COUNT_OUT_W'(back_count);

endmodule

// File: rtl/sov_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the segment obstacle visibility block, bound to
// the top level. Depends on sov_pkg and segment_obstacle_visibility_assert.svh.
`include "segment_obstacle_visibility_assert.svh"

module sov_checker import sov_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   push,
  input logic                   full,
  input logic                   empty,
  input logic                   pop,
  input logic                   out_visible,
  input logic                   out_status,
  input logic [COUNT_OUT_W-1:0] out_stored_count
);

  // Both queues come out of reset empty.
  `SOV_ASSERT_ALWAYS(a_rst_no_result, !rst_n |=> empty, "result shown right after reset")
  `SOV_ASSERT_ALWAYS(a_rst_not_full, !rst_n |=> !full, "queue full right after reset")

  // A dropped add is never also a visible query.
  `SOV_ASSERT(a_vis_status_excl, !empty |-> !(out_visible && out_status), "visible with status")

  // A waiting result holds until its transfer.
  `SOV_ASSERT(a_result_hold, (!empty && !pop) |=> (!empty && $stable(out_visible) && $stable(out_status) && $stable(out_stored_count)), "waiting result changed")

endmodule

bind segment_obstacle_visibility sov_checker u_sov_checker (.*);
